/* hw/rtl/prls_pkg.sv */
`timescale 1ns / 1ps

package prls_pkg;

	// default width of the modular millisecond time base
	localparam int TIME_BITS_DEFAULT = 32;

	// register reset values
	localparam logic [7:0]  RST_ACK          = 8'd6;
	localparam logic [7:0]  RST_NAK          = 8'd21;
	localparam logic [15:0] RST_RETRY        = 16'd1000;
	localparam logic [15:0] RST_SEND_TIMEOUT = 16'd3000;
	localparam logic [15:0] RST_STARTUP      = 16'd3000;
	localparam logic [15:0] RST_IDLE         = 16'd10000;
	localparam logic [15:0] RST_MIN_RESET    = 16'd5000;

	// register indexes (byte address is 4 * index)
	localparam logic [2:0] REG_ACK          = 3'd0;
	localparam logic [2:0] REG_NAK          = 3'd1;
	localparam logic [2:0] REG_RETRY        = 3'd2;
	localparam logic [2:0] REG_SEND_TIMEOUT = 3'd3;
	localparam logic [2:0] REG_STARTUP      = 3'd4;
	localparam logic [2:0] REG_IDLE         = 3'd5;
	localparam logic [2:0] REG_MIN_RESET    = 3'd6;

	// packet kinds
	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_POLL   = 2'd1;
	localparam logic [1:0] KIND_CREDIT = 2'd2;

	typedef struct packed {
		logic [7:0]  ack_code;
		logic [7:0]  nak_code;
		logic [15:0] retry_interval_ms;
		logic [15:0] send_timeout_ms;
		logic [15:0] startup_delay_ms;
		logic [15:0] idle_timeout_ms;
		logic [15:0] min_reset_interval_ms;
	} prls_cfg_t;

	typedef struct packed {
		logic [1:0] send_kind;
		logic [7:0] send_credits;
		logic       clear_credits;
		logic       uart_restart;
		logic       link_busy;
	} prls_result_t;

endpackage

/* hw/rtl/poll_retry_link_supervisor_top.sv */
`timescale 1ns / 1ps
// A request accepted into the input register s1 has its result registered onto m_* when
// it advances. Throughput: one request per cycle while m_tready drains the result register;
// the link state update in prls_core sits between the input and result registers.
// Reset: arst_n is asynchronous, active low; it clears all link state and timers to zero and
// loads the register defaults. No clearing pass; requests are taken right after reset.

module poll_retry_link_supervisor_top #(
	parameter int TIME_BITS = prls_pkg::TIME_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// request side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] rx_byte, [15:8] credits
	input  logic        s_tuser,   // [0] mode: 0 tick, 1 received byte
	// result side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] send_credits, [8] clear_credits,
	                               // [9] uart_restart, [10] link_busy, [15:11] zero
	output logic [1:0]  m_tuser,   // [1:0] send_kind
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import prls_pkg::*;

	prls_cfg_t    cfg;
	prls_result_t res;

	// input register
	logic       valid_s1;
	logic       mode_s1;
	logic [7:0] rx_s1, cred_s1;

	// result register
	logic         out_valid_q;
	prls_result_t out_q;

	logic advance;

	// the request in s1 moves on when the result slot is free or being drained
	assign advance  = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | advance;

	prls_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	prls_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.mode    (mode_s1),
		.rx_byte (rx_s1),
		.credits (cred_s1),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1 <= s_tuser;
			rx_s1   <= s_tdata[7:0];
			cred_s1 <= s_tdata[15:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.send_kind;
	assign m_tdata  = {5'd0, out_q.link_busy, out_q.uart_restart, out_q.clear_credits,
		out_q.send_credits};

	// a credit packet always tells the counter to clear
	a_credit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_CREDIT) |-> m_tdata[8])
		else $error("credit packet without clear");

	// a UART restart always goes with a poll packet
	a_restart_polls: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[9] |-> (m_tuser == KIND_POLL))
		else $error("restart without poll packet");

	// anything sent leaves the link waiting for an acknowledge
	a_sent_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != KIND_NONE) |-> m_tdata[10])
		else $error("packet sent but link not busy");

	// a stalled result with a request waiting in s1 blocks the input
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !m_tready |-> !s_tready)
		else $error("input accepted while pipeline full");

	// a request held in s1 during a stall is still there next cycle
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("request lost from input register");

endmodule

/* hw/rtl/prls_regs.sv */
`timescale 1ns / 1ps

module prls_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output prls_pkg::prls_cfg_t cfg
);
	import prls_pkg::*;

	prls_cfg_t  cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ack_code              <= RST_ACK;
			cfg_q.nak_code              <= RST_NAK;
			cfg_q.retry_interval_ms     <= RST_RETRY;
			cfg_q.send_timeout_ms       <= RST_SEND_TIMEOUT;
			cfg_q.startup_delay_ms      <= RST_STARTUP;
			cfg_q.idle_timeout_ms       <= RST_IDLE;
			cfg_q.min_reset_interval_ms <= RST_MIN_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_ACK:          cfg_q.ack_code              <= pwdata[7:0];
				REG_NAK:          cfg_q.nak_code              <= pwdata[7:0];
				REG_RETRY:        cfg_q.retry_interval_ms     <= pwdata[15:0];
				REG_SEND_TIMEOUT: cfg_q.send_timeout_ms       <= pwdata[15:0];
				REG_STARTUP:      cfg_q.startup_delay_ms      <= pwdata[15:0];
				REG_IDLE:         cfg_q.idle_timeout_ms       <= pwdata[15:0];
				REG_MIN_RESET:    cfg_q.min_reset_interval_ms <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ACK:          prdata = {24'd0, cfg_q.ack_code};
			REG_NAK:          prdata = {24'd0, cfg_q.nak_code};
			REG_RETRY:        prdata = {16'd0, cfg_q.retry_interval_ms};
			REG_SEND_TIMEOUT: prdata = {16'd0, cfg_q.send_timeout_ms};
			REG_STARTUP:      prdata = {16'd0, cfg_q.startup_delay_ms};
			REG_IDLE:         prdata = {16'd0, cfg_q.idle_timeout_ms};
			REG_MIN_RESET:    prdata = {16'd0, cfg_q.min_reset_interval_ms};
			default:          prdata = 32'd0;
		endcase
	end

endmodule

/* hw/rtl/prls_core.sv */
`timescale 1ns / 1ps

module prls_core #(
	parameter int TIME_BITS = prls_pkg::TIME_BITS_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic                   mode,
	input  logic [7:0]             rx_byte,
	input  logic [7:0]             credits,
	input  prls_pkg::prls_cfg_t    cfg,
	output prls_pkg::prls_result_t res
);
	import prls_pkg::*;

	localparam int TW = TIME_BITS;

	logic [TW-1:0] now_q, last_att_q, series_q, last_act_q, last_rst_q;
	logic          started_q, awaiting_q;
	logic [7:0]    last_cred_q;

	logic [TW-1:0] now_n, last_att_n, series_n, last_act_n, last_rst_n;
	logic          started_n, awaiting_n;
	logic [7:0]    last_cred_n;

	logic [TW-1:0] now_t, series_end, retry_at;
	logic          idle_exp, too_soon, new_cred;
	logic [1:0]    kind;
	logic          restart;

	// time after the tick and the deadlines it is checked against
	assign now_t      = now_q + TW'(1);
	assign series_end = series_q + TW'(cfg.send_timeout_ms);
	assign retry_at   = last_att_q + TW'(cfg.retry_interval_ms);
	assign idle_exp   = (now_t - last_act_q) > TW'(cfg.idle_timeout_ms);
	assign too_soon   = ((now_t - last_rst_q) < TW'(cfg.min_reset_interval_ms))
		&& (last_rst_q != '0);
	assign new_cred   = (credits != 8'd0) && (credits != last_cred_q);

	always_comb begin
		now_n       = now_q;
		started_n   = started_q;
		awaiting_n  = awaiting_q;
		last_att_n  = last_att_q;
		series_n    = series_q;
		last_cred_n = last_cred_q;
		last_act_n  = last_act_q;
		last_rst_n  = last_rst_q;
		kind        = KIND_NONE;
		restart     = 1'b0;
		if (mode) begin
			last_act_n = now_q;
			if (rx_byte == cfg.ack_code) begin
				awaiting_n  = 1'b0;
				last_att_n  = '0;
				series_n    = '0;
				last_cred_n = 8'd0;
			end
		end else begin
			now_n     = now_t;
			started_n = started_q | (now_t >= TW'(cfg.startup_delay_ms));
			if (started_n && idle_exp) begin
				awaiting_n  = 1'b0;
				last_att_n  = '0;
				series_n    = '0;
				last_cred_n = 8'd0;
				last_act_n  = now_t;
				if (!too_soon) begin
					restart    = 1'b1;
					last_rst_n = now_t;
					series_n   = now_t;
					last_att_n = now_t;
					awaiting_n = 1'b1;
					kind       = KIND_POLL;
				end
			end else if (started_n && !awaiting_q) begin
				if (new_cred) begin
					last_cred_n = credits;
					series_n    = now_t;
					last_att_n  = now_t;
					awaiting_n  = 1'b1;
					last_act_n  = now_t;
					kind        = KIND_CREDIT;
				end else if ((now_t > series_end) || (series_q == '0)) begin
					series_n   = now_t;
					last_att_n = now_t;
					awaiting_n = 1'b1;
					last_act_n = now_t;
					kind       = KIND_POLL;
				end
			end else if (started_n) begin
				// resend inside the series
				if ((now_t > retry_at) && (now_t < series_end)) begin
					last_att_n = now_t;
					last_act_n = now_t;
					if (new_cred) begin
						last_cred_n = credits;
						kind        = KIND_CREDIT;
					end else begin
						kind = KIND_POLL;
					end
				end
				// series over: start a fresh one
				if (now_t > series_end) begin
					series_n   = now_t;
					last_att_n = now_t;
					awaiting_n = 1'b1;
					last_act_n = now_t;
					if (credits != 8'd0) begin
						last_cred_n = credits;
						kind        = KIND_CREDIT;
					end else begin
						last_cred_n = 8'd0;
						kind        = KIND_POLL;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q       <= '0;
			started_q   <= 1'b0;
			awaiting_q  <= 1'b0;
			last_att_q  <= '0;
			series_q    <= '0;
			last_cred_q <= 8'd0;
			last_act_q  <= '0;
			last_rst_q  <= '0;
		end else if (advance) begin
			now_q       <= now_n;
			started_q   <= started_n;
			awaiting_q  <= awaiting_n;
			last_att_q  <= last_att_n;
			series_q    <= series_n;
			last_cred_q <= last_cred_n;
			last_act_q  <= last_act_n;
			last_rst_q  <= last_rst_n;
		end
	end

	assign res.send_kind     = kind;
	assign res.send_credits  = (kind == KIND_CREDIT) ? credits : 8'd0;
	assign res.clear_credits = (kind == KIND_CREDIT);
	assign res.uart_restart  = restart;
	assign res.link_busy     = awaiting_n;

endmodule
